// ----- sv/nlt_pkg.sv -----
// Shared constants and codes for the node liveness table.
// No dependencies; the core, the register port and the bench import this package.
`default_nettype none

package nlt_pkg;

	// table geometry
	localparam int NODE_COUNT    = 32;
	localparam int PAYLOAD_BYTES = 2;
	localparam int IDX_W         = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int ADDR_W        = 8;
	localparam int ELAPSED_W     = 16;
	localparam int COUNT_W       = 6;

	localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NODE_COUNT - 1);
	localparam logic [ADDR_W:0]   MAX_ADDR   = (ADDR_W + 1)'(NODE_COUNT);
	localparam logic [ADDR_W-1:0] PAY_MAX    = ADDR_W'(PAYLOAD_BYTES);

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic           REG_TIMEOUT   = 1'b0;
	localparam logic [15:0]    TIMEOUT_RESET = 16'd1000;

	// action codes
	localparam logic [2:0] ACT_STAMP  = 3'd0;
	localparam logic [2:0] ACT_TICK   = 3'd1;
	localparam logic [2:0] ACT_CLEAR  = 3'd2;
	localparam logic [2:0] ACT_QUERY  = 3'd3;
	localparam logic [2:0] ACT_REPORT = 3'd4;
	localparam logic [2:0] ACT_COUNT  = 3'd5;

endpackage

`default_nettype wire

// ----- sv/nlt_ifs.sv -----
// Valid/ready channel interfaces for request items and result items.
// Depends on nothing; field widths follow the item layout.
`default_nettype none

interface nlt_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] node_address;
	logic [7:0] node_kind;
	logic [7:0] payload_len;
	logic [7:0] payload_first;
	logic [7:0] payload_second;

	modport source (output valid, action, node_address, node_kind, payload_len,
		payload_first, payload_second, input ready);
	modport sink (input valid, action, node_address, node_kind, payload_len,
		payload_first, payload_second, output ready);
endinterface

interface nlt_rsp_if;
	logic       valid;
	logic       ready;
	logic       present;
	logic       report_valid;
	logic [7:0] report_address;
	logic [7:0] report_kind;
	logic [7:0] report_payload_first;
	logic [7:0] report_payload_second;
	logic [5:0] failed_count;

	modport source (output valid, present, report_valid, report_address, report_kind,
		report_payload_first, report_payload_second, failed_count, input ready);
	modport sink (input valid, present, report_valid, report_address, report_kind,
		report_payload_first, report_payload_second, failed_count, output ready);
endinterface

`default_nettype wire

// ----- sv/node_liveness_table_core.sv -----
// Node liveness table: per-node presence, timers and timeout reports.
// Depends on nlt_pkg, nlt_ifs (nlt_req_if, nlt_rsp_if) and nlt_apb_regs.
//
// Usage: each transfer on req carries one action; each action returns exactly
// one transfer on rsp. Stamp, clear and query act on one entry directly; their
// result is registered in the pending result, then in the output register once
// it is free. Tick, report and count walk the table one entry per cycle through
// a single timer compare unit, fed by the registered read of the entry memories,
// and then load the output register once it is free. A report stops at the
// first unreported timed-out node, so it can finish before the last entry.
// req.ready is high only while no action is in progress; an action
// may be taken while the previous result still waits on rsp. If rsp stalls,
// a finished walk holds its result until the output register frees up.
// The timeout limit is written over the APB port at byte address 0.
// Reset clears all presence, use and report flags and sets the limit to
// 1000; the timer, type and payload memories need no clearing pass, since
// per-entry flags qualify every read.
`default_nettype none

module node_liveness_table_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	nlt_req_if.sink                             req,
	nlt_rsp_if.source                           rsp,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [nlt_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [nlt_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [nlt_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                pready
);
	import nlt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [15:0] timeout_limit;

	nlt_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_limit (timeout_limit)
	);

	// control state
	logic [1:0]            state_q;
	logic [2:0]            act_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  issue_q;
	logic                  chk_v_s1;
	logic [IDX_W-1:0]      chk_idx_s1;

	// per-entry flags
	logic [NODE_COUNT-1:0] used_q;
	logic [NODE_COUNT-1:0] present_q;
	logic [NODE_COUNT-1:0] reported_q;
	logic [NODE_COUNT-1:0] pay0_v_q;
	logic [NODE_COUNT-1:0] pay1_v_q;

	// entry memories
	logic [ELAPSED_W-1:0]  el_mem [NODE_COUNT];
	logic [7:0]            kind_mem [NODE_COUNT];
	logic [7:0]            pay0_mem [NODE_COUNT];
	logic [7:0]            pay1_mem [NODE_COUNT];
	logic [ELAPSED_W-1:0]  rd_el_q;
	logic [7:0]            rd_kind_q;
	logic [7:0]            rd_pay0_q;
	logic [7:0]            rd_pay1_q;

	// pending result
	logic                  res_present_q;
	logic                  res_rvalid_q;
	logic [ADDR_W-1:0]     res_addr_q;
	logic [7:0]            res_kind_q;
	logic [7:0]            res_pay0_q;
	logic [7:0]            res_pay1_q;
	logic [COUNT_W-1:0]    res_failed_q;

	// output register
	logic                  out_valid_q;
	logic                  out_present_q;
	logic                  out_rvalid_q;
	logic [ADDR_W-1:0]     out_addr_q;
	logic [7:0]            out_kind_q;
	logic [7:0]            out_pay0_q;
	logic [7:0]            out_pay1_q;
	logic [COUNT_W-1:0]    out_failed_q;

	logic                  acc;
	logic                  out_free;
	logic                  addr_ok;
	logic [IDX_W-1:0]      acc_idx;
	logic [ADDR_W-1:0]     addr_m1;
	logic                  pay_ok;
	logic                  walk_step;
	logic                  walk_last;

	// shared timer unit
	logic [ELAPSED_W-1:0]  e_cur;
	logic [ELAPSED_W-1:0]  e_op;
	logic                  e_gt;
	logic                  hit;

	// memory write ports
	logic                  el_we;
	logic [IDX_W-1:0]      el_wa;
	logic [ELAPSED_W-1:0]  el_wd;
	logic                  kind_we;
	logic [7:0]            kind_wd;
	logic                  pay0_we;
	logic                  pay1_we;

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// decode the request address
	assign addr_ok = (req.node_address != '0) && ({1'b0, req.node_address} <= MAX_ADDR);
	assign addr_m1 = req.node_address - ADDR_W'(1);
	assign acc_idx = addr_m1[IDX_W-1:0];
	assign pay_ok  = (req.payload_len != '0) && (req.payload_len <= PAY_MAX);

	assign walk_step = (state_q == ST_WALK) && chk_v_s1;
	assign walk_last = (chk_idx_s1 == LAST_IDX);

	// timer compare: saturating increment on tick, plain compare otherwise
	always_comb begin
		e_cur = used_q[chk_idx_s1] ? rd_el_q : '0;
		e_op  = e_cur;
		if ((act_q == ACT_TICK) && (e_cur != '1)) begin
			e_op = e_cur + ELAPSED_W'(1);
		end
		e_gt = (e_op > timeout_limit);
		hit  = e_gt && !reported_q[chk_idx_s1];
	end

	// select what the entry memories write this cycle
	always_comb begin
		el_we   = 1'b0;
		el_wa   = acc_idx;
		el_wd   = '0;
		kind_we = 1'b0;
		kind_wd = '0;
		pay0_we = 1'b0;
		pay1_we = 1'b0;
		if (acc && addr_ok && ((req.action == ACT_STAMP) || (req.action == ACT_CLEAR))) begin
			el_we   = 1'b1;
			kind_we = 1'b1;
			if (req.action == ACT_STAMP) begin
				kind_wd = req.node_kind;
				pay0_we = pay_ok;
				pay1_we = pay_ok && (req.payload_len >= 8'd2);
			end
		end
		if (walk_step && (act_q == ACT_TICK) && used_q[chk_idx_s1] && present_q[chk_idx_s1]) begin
			el_we = 1'b1;
			el_wa = chk_idx_s1;
			el_wd = e_op;
		end
	end

	// entry memories: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (el_we) begin
			el_mem[el_wa] <= el_wd;
		end
		if (kind_we) begin
			kind_mem[acc_idx] <= kind_wd;
		end
		if (pay0_we) begin
			pay0_mem[acc_idx] <= req.payload_first;
		end
		if (pay1_we) begin
			pay1_mem[acc_idx] <= req.payload_second;
		end
		rd_el_q   <= el_mem[rd_idx_q];
		rd_kind_q <= kind_mem[rd_idx_q];
		rd_pay0_q <= pay0_mem[rd_idx_q];
		rd_pay1_q <= pay1_mem[rd_idx_q];
	end

	// sequencer, entry flags and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			act_q         <= ACT_STAMP;
			rd_idx_q      <= '0;
			issue_q       <= 1'b0;
			chk_v_s1      <= 1'b0;
			chk_idx_s1    <= '0;
			used_q        <= '0;
			present_q     <= '0;
			reported_q    <= '0;
			pay0_v_q      <= '0;
			pay1_v_q      <= '0;
			res_present_q <= 1'b0;
			res_rvalid_q  <= 1'b0;
			res_addr_q    <= '0;
			res_kind_q    <= '0;
			res_pay0_q    <= '0;
			res_pay1_q    <= '0;
			res_failed_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						act_q         <= req.action;
						res_present_q <= 1'b0;
						res_rvalid_q  <= 1'b0;
						res_addr_q    <= '0;
						res_kind_q    <= '0;
						res_pay0_q    <= '0;
						res_pay1_q    <= '0;
						res_failed_q  <= '0;
						rd_idx_q      <= '0;
						chk_v_s1      <= 1'b0;
						state_q       <= ST_FIN;
						case (req.action)
							ACT_STAMP: begin
								if (addr_ok) begin
									used_q[acc_idx]     <= 1'b1;
									present_q[acc_idx]  <= 1'b1;
									reported_q[acc_idx] <= 1'b0;
									if (pay0_we) begin
										pay0_v_q[acc_idx] <= 1'b1;
									end
									if (pay1_we) begin
										pay1_v_q[acc_idx] <= 1'b1;
									end
								end
							end
							ACT_CLEAR: begin
								if (addr_ok) begin
									used_q[acc_idx]     <= 1'b0;
									present_q[acc_idx]  <= 1'b0;
									reported_q[acc_idx] <= 1'b0;
								end
							end
							ACT_QUERY: begin
								res_present_q <= addr_ok && present_q[acc_idx];
							end
							ACT_TICK, ACT_REPORT, ACT_COUNT: begin
								issue_q <= 1'b1;
								state_q <= ST_WALK;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					// issue reads in index order
					chk_v_s1   <= issue_q;
					chk_idx_s1 <= rd_idx_q;
					if (issue_q) begin
						if (rd_idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + IDX_W'(1);
						end
					end
					// act on the entry whose data just came back
					if (chk_v_s1) begin
						case (act_q)
							ACT_TICK: begin
								if (used_q[chk_idx_s1] && present_q[chk_idx_s1] && e_gt) begin
									present_q[chk_idx_s1] <= 1'b0;
								end
							end
							ACT_REPORT: begin
								if (hit) begin
									reported_q[chk_idx_s1] <= 1'b1;
									res_rvalid_q <= 1'b1;
									res_addr_q   <= ADDR_W'(chk_idx_s1) + ADDR_W'(1);
									res_kind_q   <= rd_kind_q;
									res_pay0_q   <= pay0_v_q[chk_idx_s1] ? rd_pay0_q : '0;
									res_pay1_q   <= pay1_v_q[chk_idx_s1] ? rd_pay1_q : '0;
								end
							end
							ACT_COUNT: begin
								if (hit && (res_failed_q != '1)) begin
									res_failed_q <= res_failed_q + COUNT_W'(1);
								end
							end
							default: begin
							end
						endcase
						if (walk_last || ((act_q == ACT_REPORT) && hit)) begin
							state_q  <= ST_FIN;
							issue_q  <= 1'b0;
							chk_v_s1 <= 1'b0;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: load on finish, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_present_q <= res_present_q;
			out_rvalid_q  <= res_rvalid_q;
			out_addr_q    <= res_addr_q;
			out_kind_q    <= res_kind_q;
			out_pay0_q    <= res_pay0_q;
			out_pay1_q    <= res_pay1_q;
			out_failed_q  <= res_failed_q;
		end
	end

	assign rsp.valid                 = out_valid_q;
	assign rsp.present               = out_present_q;
	assign rsp.report_valid          = out_rvalid_q;
	assign rsp.report_address        = out_addr_q;
	assign rsp.report_kind           = out_kind_q;
	assign rsp.report_payload_first  = out_pay0_q;
	assign rsp.report_payload_second = out_pay1_q;
	assign rsp.failed_count          = out_failed_q;

`ifndef SYNTHESIS
	// an accepted action always keeps the block busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready)
		else $error("request taken while an action was in progress");

	// a present node is always a used node
	a_present_used: assert property (@(posedge clk) disable iff (!arst_n)
		(present_q & ~used_q) == '0)
		else $error("present flag set on an unused entry");

	// a report names a node inside the table
	a_report_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.report_valid) |->
		((rsp.report_address != '0) && ({1'b0, rsp.report_address} <= MAX_ADDR)))
		else $error("report address outside the table");

	// the failure count cannot exceed the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ({3'b000, rsp.failed_count} <= MAX_ADDR))
		else $error("failure count beyond table size");
`endif

endmodule

`default_nettype wire

// ----- sv/nlt_apb_regs.sv -----
// APB-style register port holding the timeout limit.
// Depends on nlt_pkg.
`default_nettype none

module nlt_apb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [nlt_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [nlt_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [nlt_pkg::CFG_DATA_W-1:0] prdata,
	output logic                              pready,
	output logic      [15:0]                  timeout_limit
);
	import nlt_pkg::*;

	logic [15:0] limit_q;
	logic        wr_en;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[CFG_ADDR_W-1];
	assign wr_en   = psel && penable && pwrite && pready;

	// write the limit in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= TIMEOUT_RESET;
		end else if (wr_en && (reg_sel == REG_TIMEOUT)) begin
			limit_q <= pwdata[15:0];
		end
	end

	// read back; addresses past the register answer zero
	always_comb begin
		prdata = '0;
		if (reg_sel == REG_TIMEOUT) begin
			prdata = {{(CFG_DATA_W-16){1'b0}}, limit_q};
		end
	end

	assign timeout_limit = limit_q;

endmodule

`default_nettype wire

// ----- bench/tb_node_liveness_table_core.sv -----
// Self-checking bench for node_liveness_table_core: a directed pass, then phases of random
// actions under several timeout limits, all checked against a cycle-free table model.
// Depends on nlt_pkg, nlt_ifs (nlt_req_if, nlt_rsp_if) and the core itself.

package liveness_check_pkg;
	import nlt_pkg::*;

	// actions outside the defined set; the core must answer them with all zeros
	localparam logic [2:0] ACT_SPARE_LOW  = 3'd6;
	localparam logic [2:0] ACT_SPARE_HIGH = 3'd7;
	localparam int         COUNT_MAX      = 63;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] node_address;
		logic [7:0] node_kind;
		logic [7:0] payload_len;
		logic [7:0] payload_first;
		logic [7:0] payload_second;
	} request_t;

	typedef struct packed {
		logic       present;
		logic       report_valid;
		logic [7:0] report_address;
		logic [7:0] report_kind;
		logic [7:0] report_payload_first;
		logic [7:0] report_payload_second;
		logic [5:0] failed_count;
	} result_t;

	class liveness_scoreboard;
		bit [15:0] limit;
		bit        used [NODE_COUNT];
		bit        alive [NODE_COUNT];
		bit        reported [NODE_COUNT];
		bit [15:0] elapsed [NODE_COUNT];
		bit [7:0]  kind [NODE_COUNT];
		bit [15:0] payload [NODE_COUNT];
		result_t   pending_results [$];
		int        action_seen [8];
		int        reports_found;
		int        results_checked;
		int        mismatches;

		function new();
			limit = TIMEOUT_RESET;
		endfunction

		function bit in_table(logic [7:0] addr);
			return addr >= 1 && addr <= NODE_COUNT;
		endfunction

		function bit timed_out(int n);
			return elapsed[n] > limit && !reported[n];
		endfunction

		// apply one accepted action to the table copy and queue the answer it must give
		function void note_request(request_t rq);
			result_t want;
			int      n;
			int      cnt;
			bit      found;
			want  = '0;
			n     = int'(rq.node_address) - 1;
			cnt   = 0;
			found = 0;
			action_seen[rq.action]++;
			case (rq.action)
				ACT_STAMP: if (in_table(rq.node_address)) begin
					used[n]  = 1'b1;
					alive[n] = 1'b1;
					kind[n]  = rq.node_kind;
					if (rq.payload_len >= 1 && rq.payload_len <= PAYLOAD_BYTES) begin
						payload[n][7:0] = rq.payload_first;
						if (rq.payload_len >= 2)
							payload[n][15:8] = rq.payload_second;
					end
					elapsed[n]  = '0;
					reported[n] = 1'b0;
				end
				ACT_TICK: for (int i = 0; i < NODE_COUNT; i++) begin
					if (used[i] && alive[i]) begin
						// timer sticks at its ceiling
						if (elapsed[i] != 16'hFFFF)
							elapsed[i]++;
						if (elapsed[i] > limit)
							alive[i] = 1'b0;
					end
				end
				ACT_CLEAR: if (in_table(rq.node_address)) begin
					// stored payload survives a clear
					used[n]     = 1'b0;
					alive[n]    = 1'b0;
					reported[n] = 1'b0;
					elapsed[n]  = '0;
					kind[n]     = '0;
				end
				ACT_QUERY: if (in_table(rq.node_address))
					want.present = alive[n];
				ACT_REPORT: for (int i = 0; i < NODE_COUNT; i++) begin
					// lowest timed-out node only
					if (!found && timed_out(i)) begin
						found                      = 1'b1;
						reported[i]                = 1'b1;
						want.report_valid          = 1'b1;
						want.report_address        = 8'(i + 1);
						want.report_kind           = kind[i];
						want.report_payload_first  = payload[i][7:0];
						want.report_payload_second = payload[i][15:8];
						reports_found++;
					end
				end
				ACT_COUNT: begin
					for (int i = 0; i < NODE_COUNT; i++)
						if (timed_out(i) && cnt < COUNT_MAX)
							cnt++;
					want.failed_count = 6'(cnt);
				end
				default: ;
			endcase
			pending_results.push_back(want);
		endfunction

		function bit field_differs(string name, logic [7:0] want, logic [7:0] seen,
			longint at_ns);
			if (want !== seen) begin
				$display("[%0d ns] result %0d %s: expected 0x%0h, got 0x%0h",
					at_ns, results_checked, name, want, seen);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(result_t seen, longint at_ns);
			result_t want;
			bit      bad;
			if (pending_results.size() == 0) begin
				$display("[%0d ns] result with nothing expected: expected none, got 0x%0h",
					at_ns, seen);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			results_checked++;
			bad = 1'b0;
			bad |= field_differs("present", 8'(want.present), 8'(seen.present), at_ns);
			bad |= field_differs("report_valid", 8'(want.report_valid),
				8'(seen.report_valid), at_ns);
			bad |= field_differs("report_address", want.report_address,
				seen.report_address, at_ns);
			bad |= field_differs("report_kind", want.report_kind, seen.report_kind, at_ns);
			bad |= field_differs("report_payload_first", want.report_payload_first,
				seen.report_payload_first, at_ns);
			bad |= field_differs("report_payload_second", want.report_payload_second,
				seen.report_payload_second, at_ns);
			bad |= field_differs("failed_count", 8'(want.failed_count),
				8'(seen.failed_count), at_ns);
			if (bad)
				mismatches++;
		endfunction
	endclass

endpackage

module tb_node_liveness_table_core;
	timeunit 1ns;
	timeprecision 1ps;

	import nlt_pkg::*;
	import liveness_check_pkg::*;

	localparam int IDLE_PCT       = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 50;
	localparam int PHASE_ITEMS    = 165;
	localparam int PHASES         = 6;
	localparam int CALM_PHASE     = 2;
	localparam int HOLD_PHASE     = 1;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	nlt_req_if req ();
	nlt_rsp_if rsp ();

	liveness_scoreboard sb;
	bit                 calm;
	bit                 hold_request;
	bit                 hold_done;
	int                 hold_left;
	int                 idle_cycles;
	bit [15:0]          phase_limits [PHASES] = '{16'd1, 16'd3, 16'd8, 16'd65534, 16'd2,
		16'd20};

	node_liveness_table_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one action and hold it until the core takes it
	task automatic send_request(request_t rq);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid          <= 1'b1;
		req.action         <= rq.action;
		req.node_address   <= rq.node_address;
		req.node_kind      <= rq.node_kind;
		req.payload_len    <= rq.payload_len;
		req.payload_first  <= rq.payload_first;
		req.payload_second <= rq.payload_second;
		do @(posedge clk); while (!req.ready);
		sb.note_request(rq);
	endtask

	task automatic send_action(logic [2:0] act, logic [7:0] addr, logic [7:0] kind,
		logic [7:0] len, logic [7:0] first, logic [7:0] second);
		request_t rq;
		rq = '{act, addr, kind, len, first, second};
		send_request(rq);
	endtask

	// drop valid and wait for every outstanding answer
	task automatic wait_drained();
		req.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	task automatic write_limit(bit [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(4 * int'(REG_TIMEOUT));
		pwdata  <= CFG_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		sb.limit = value;
	endtask

	function automatic request_t random_request();
		request_t rq;
		int       pick;
		rq.node_kind      = 8'($urandom);
		rq.payload_first  = 8'($urandom);
		rq.payload_second = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 28)
			rq.action = ACT_TICK;
		else if (pick < 55)
			rq.action = ACT_STAMP;
		else if (pick < 70)
			rq.action = ACT_QUERY;
		else if (pick < 82)
			rq.action = ACT_REPORT;
		else if (pick < 92)
			rq.action = ACT_COUNT;
		else
			rq.action = ACT_CLEAR;
		// mostly table addresses, now and then anything the field holds
		if ($urandom_range(0, 9) == 0)
			rq.node_address = 8'($urandom);
		else
			rq.node_address = 8'($urandom_range(1, NODE_COUNT));
		if ($urandom_range(0, 4) == 0)
			rq.payload_len = 8'($urandom);
		else
			rq.payload_len = 8'($urandom_range(0, PAYLOAD_BYTES + 1));
		return rq;
	endfunction

	// result side: check each transfer, then pick the next ready
	always @(posedge clk) begin : result_side
		result_t seen;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				seen = {rsp.present, rsp.report_valid, rsp.report_address, rsp.report_kind,
					rsp.report_payload_first, rsp.report_payload_second, rsp.failed_count};
				sb.check_result(seen, $time);
			end
			if (hold_request && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
			end
		end else begin
			rsp.ready <= 1'b0;
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0d ns] no transfer for %0d cycles, %0d results outstanding",
				$time, idle_cycles, sb.pending_results.size());
			$display("tb_node_liveness_table_core failed");
			$finish;
		end
	end

	initial begin : stimulus
		sb                 = new();
		arst_n             = 1'b0;
		req.valid          = 1'b0;
		req.action         = ACT_STAMP;
		req.node_address   = '0;
		req.node_kind      = '0;
		req.payload_len    = '0;
		req.payload_first  = '0;
		req.payload_second = '0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first and last entries, bad addresses, payload lengths 0, 1, 2, 3 and 255
		send_action(ACT_STAMP, 8'd1, 8'hFF, 8'd2, 8'hFF, 8'h00);
		send_action(ACT_STAMP, 8'(NODE_COUNT), 8'h00, 8'd1, 8'hA5, 8'h5A);
		send_action(ACT_STAMP, 8'd0, 8'h11, 8'd2, 8'h22, 8'h33);
		send_action(ACT_STAMP, 8'(NODE_COUNT + 1), 8'h44, 8'd2, 8'h55, 8'h66);
		send_action(ACT_STAMP, 8'hFF, 8'h77, 8'd1, 8'h88, 8'h99);
		send_action(ACT_STAMP, 8'd5, 8'h80, 8'd0, 8'hFF, 8'hFF);
		send_action(ACT_STAMP, 8'd6, 8'h7F, 8'd3, 8'hAA, 8'hBB);
		send_action(ACT_STAMP, 8'd7, 8'h01, 8'hFF, 8'hCC, 8'hDD);
		send_action(ACT_QUERY, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_QUERY, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_QUERY, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_COUNT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_REPORT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		wait_drained();

		// zero limit: one tick times out every live node; reports go lowest first
		write_limit(16'd0);
		send_action(ACT_STAMP, 8'd9, 8'h55, 8'd2, 8'h00, 8'hFF);
		send_action(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_COUNT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_REPORT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_REPORT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_CLEAR, 8'(NODE_COUNT), 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_CLEAR, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_QUERY, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_STAMP, 8'd1, 8'h3C, 8'd1, 8'h0F, 8'hF0);
		send_action(ACT_SPARE_LOW, 8'd3, 8'hFF, 8'd2, 8'hFF, 8'hFF);
		send_action(ACT_SPARE_HIGH, 8'd4, 8'hFF, 8'd2, 8'hFF, 8'hFF);
		wait_drained();

		// top limit: nothing can time out
		write_limit(16'hFFFF);
		send_action(ACT_TICK, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_COUNT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		send_action(ACT_REPORT, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
		wait_drained();

		// random phases, each under its own limit
		for (int phase = 0; phase < PHASES; phase++) begin
			calm = (phase == CALM_PHASE);
			write_limit(phase_limits[phase]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// back-pressure the result side long enough to fill the core
				if (phase == HOLD_PHASE && k == 40)
					hold_request = 1'b1;
				send_request(random_request());
			end
			wait_drained();
		end
		calm = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d stamps, %0d ticks, %0d clears, %0d queries, %0d counts,",
			sb.action_seen[ACT_STAMP], sb.action_seen[ACT_TICK], sb.action_seen[ACT_CLEAR],
			sb.action_seen[ACT_QUERY], sb.action_seen[ACT_COUNT]);
		$display("%0d report takes (%0d found), %0d unused actions; %0d results checked",
			sb.action_seen[ACT_REPORT], sb.reports_found,
			sb.action_seen[ACT_SPARE_LOW] + sb.action_seen[ACT_SPARE_HIGH],
			sb.results_checked);
		if (sb.pending_results.size() != 0)
			$display("%0d expected results never arrived", sb.pending_results.size());
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("tb_node_liveness_table_core passed");
		else
			$display("tb_node_liveness_table_core failed");
		$finish;
	end

endmodule
